### design/priority_time_slice_scheduler_assert.svh
// Assertion macros for the priority time-slice scheduler.
`ifndef PRIORITY_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define PRIORITY_TIME_SLICE_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, held off while reset is asserted.
`define PTSS_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define PTSS_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTSS_ASSERT_RST(label, clk, rst_n, prop, msg)
`define PTSS_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

### design/ptss_pkg.sv
// Shared types and constants of the priority time-slice scheduler.
`timescale 1ns / 1ps

package ptss_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Payload field widths.
  localparam int ACTION_W = 2;
  localparam int FIELD_W  = 4;
  localparam int PRIO_W   = 8;
  localparam int SLICE_W  = 8;
  localparam int STATE_W  = 2;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_LOAD      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_STATE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE  = 2'd2;

  // Task state as stored in a slot.
  typedef enum logic [STATE_W-1:0] {
    ST_BLOCKED = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } task_state_t;

  // One slot of the task table.
  typedef struct packed {
    logic                occ;
    logic [PRIO_W-1:0]   prio;
    logic [SLICE_W-1:0]  slice;
    task_state_t         state;
  } entry_t;

  // Request from the sequencer to the slot memory.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  // Running selection while the table is scanned.
  typedef struct packed {
    logic               have;
    logic [SLOT_W-1:0]  idx;
    logic [PRIO_W-1:0]  prio;
    logic [SLICE_W-1:0] slice;
  } pick_t;

endpackage

### design/priority_time_slice_scheduler.sv
// Top level of the priority time-slice scheduler: handshake, sequencer and result register.
// The block holds SLOT_COUNT task slots in a memory with one write port and one
// registered read port, and handles one transaction at a time. A load or an unused
// action goes straight to the result stage, a state change reads, modifies and
// writes its slot. A schedule decision reads the table one slot per cycle in two
// passes, first to find occupied slots and exhausted slices, then to refill, demote
// the current task and compare priorities, and writes the chosen slot back; the
// second pass is skipped when no slot is occupied. The next transaction is accepted
// as soon as the result sits in the output register, even while it waits to be taken.
`timescale 1ns / 1ps

module priority_time_slice_scheduler
  import ptss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [FIELD_W-1:0]  in_slot,
  input  logic                in_occupied,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic [SLICE_W-1:0]  in_time_slice,
  input  logic [STATE_W-1:0]  in_task_state,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [FIELD_W-1:0]  out_chosen_slot,
  output logic [SLICE_W-1:0]  out_remaining_slice,
  output logic                out_refilled
);

  `include "priority_time_slice_scheduler_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_WR,
    S_SCAN_A,
    S_SCAN_B,
    S_FINISH,
    S_DONE
  } fsm_t;

  // Map a raw state code onto a stored state; code three means blocked.
  function automatic task_state_t clean_state(input logic [STATE_W-1:0] v);
    task_state_t s;
    case (v)
      2'd1:    s = ST_READY;
      2'd2:    s = ST_RUNNING;
      default: s = ST_BLOCKED;
    endcase
    return s;
  endfunction

  // Slice decrement that stops at zero.
  function automatic logic [SLICE_W-1:0] sat_dec(input logic [SLICE_W-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

  fsm_t                state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  task_state_t         tstate_r, tstate_nxt;
  logic                slot_ok_r, slot_ok_nxt;
  logic                any_r, any_nxt;
  logic                allz_r, allz_nxt;
  logic                refill_r, refill_nxt;
  pick_t               pick_r, pick_nxt;
  logic                res_found_r, res_found_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [SLICE_W-1:0]  res_slice_r, res_slice_nxt;
  logic [SLOT_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [FIELD_W-1:0]  out_slot_r, out_slot_nxt;
  logic [SLICE_W-1:0]  out_slice_r, out_slice_nxt;
  logic                out_refilled_r, out_refilled_nxt;

  mem_req_t            mem_req;
  entry_t              rd_entry;
  logic                in_fire;
  logic                in_slot_ok;
  logic [SLOT_W-1:0]   in_addr;
  logic [SLOT_W-1:0]   proc_idx;
  logic                last_cnt;
  logic                pick_wr_en;
  entry_t              pick_wr_entry;
  pick_t               pick_out;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_slot_ok = (32'(in_slot) < SLOT_COUNT);
  assign in_addr    = SLOT_W'(in_slot);
  assign proc_idx   = SLOT_W'(cnt_r - 1'b1);
  assign last_cnt   = (cnt_r == CNT_W'(SLOT_COUNT));

  ptss_slot_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  ptss_pick u_pick (
    .entry     (rd_entry),
    .idx       (proc_idx),
    .refill    (refill_r),
    .cur_valid (cur_valid_r),
    .cur_slot  (cur_slot_r),
    .pick_in   (pick_r),
    .wr_en     (pick_wr_en),
    .wr_entry  (pick_wr_entry),
    .pick_out  (pick_out)
  );

  // Sequencer next-state and memory request.
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    slot_nxt         = slot_r;
    tstate_nxt       = tstate_r;
    slot_ok_nxt      = slot_ok_r;
    any_nxt          = any_r;
    allz_nxt         = allz_r;
    refill_nxt       = refill_r;
    pick_nxt         = pick_r;
    res_found_nxt    = res_found_r;
    res_slot_nxt     = res_slot_r;
    res_slice_nxt    = res_slice_r;
    cur_slot_nxt     = cur_slot_r;
    cur_valid_nxt    = cur_valid_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_slot_nxt     = out_slot_r;
    out_slice_nxt    = out_slice_r;
    out_refilled_nxt = out_refilled_r;

    mem_req       = '0;
    mem_req.raddr = SLOT_W'(cnt_r);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_slice_nxt = '0;
          refill_nxt    = 1'b0;
          slot_nxt      = in_addr;
          tstate_nxt    = clean_state(in_task_state);
          slot_ok_nxt   = in_slot_ok;
          case (in_action)
            ACT_LOAD: begin
              if (in_slot_ok) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_addr;
                mem_req.wdata = '{occ: in_occupied, prio: in_priority_req,
                                  slice: in_time_slice,
                                  state: clean_state(in_task_state)};
                if (cur_valid_r && (cur_slot_r == in_addr)) begin
                  cur_valid_nxt = 1'b0;
                end
              end
              state_nxt = S_DONE;
            end
            ACT_SET_STATE: begin
              mem_req.raddr = in_addr;
              state_nxt     = S_SET_WR;
            end
            ACT_SCHEDULE: begin
              cnt_nxt   = '0;
              any_nxt   = 1'b0;
              allz_nxt  = 1'b1;
              state_nxt = S_SCAN_A;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Write back the slot with its new state, other fields kept.
      S_SET_WR: begin
        if (slot_ok_r) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = slot_r;
          mem_req.wdata       = rd_entry;
          mem_req.wdata.state = tstate_r;
        end
        state_nxt = S_DONE;
      end

      // First pass: any occupied slot, and whether all their slices are spent.
      S_SCAN_A: begin
        if ((cnt_r != '0) && rd_entry.occ) begin
          any_nxt = 1'b1;
          if (rd_entry.slice != '0) begin
            allz_nxt = 1'b0;
          end
        end
        if (last_cnt) begin
          cnt_nxt      = '0;
          refill_nxt   = allz_nxt;
          pick_nxt     = '0;
          state_nxt    = any_nxt ? S_SCAN_B : S_DONE;
          if (!any_nxt) begin
            refill_nxt = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Second pass: refill, demote, compare, one slot per cycle.
      S_SCAN_B: begin
        if (cnt_r != '0) begin
          pick_nxt = pick_out;
          if (pick_wr_en) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = proc_idx;
            mem_req.wdata = pick_wr_entry;
          end
        end
        if (last_cnt) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Mark the chosen slot running and spend one unit of its slice.
      S_FINISH: begin
        if (pick_r.have) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pick_r.idx;
          mem_req.wdata = '{occ: 1'b1, prio: pick_r.prio,
                            slice: sat_dec(pick_r.slice), state: ST_RUNNING};
          cur_slot_nxt  = pick_r.idx;
          cur_valid_nxt = 1'b1;
          res_found_nxt = 1'b1;
          res_slot_nxt  = pick_r.idx;
          res_slice_nxt = sat_dec(pick_r.slice);
        end
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = res_found_r;
          out_slot_nxt     = FIELD_W'(res_slot_r);
          out_slice_nxt    = res_slice_r;
          out_refilled_nxt = refill_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r         <= slot_nxt;
    tstate_r       <= tstate_nxt;
    slot_ok_r      <= slot_ok_nxt;
    any_r          <= any_nxt;
    allz_r         <= allz_nxt;
    refill_r       <= refill_nxt;
    pick_r         <= pick_nxt;
    res_found_r    <= res_found_nxt;
    res_slot_r     <= res_slot_nxt;
    res_slice_r    <= res_slice_nxt;
    out_found_r    <= out_found_nxt;
    out_slot_r     <= out_slot_nxt;
    out_slice_r    <= out_slice_nxt;
    out_refilled_r <= out_refilled_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_chosen_slot     = out_slot_r;
  assign out_remaining_slice = out_slice_r;
  assign out_refilled        = out_refilled_r;

  // A result without a chosen task carries zero slot and slice.
  `PTSS_ASSERT_RST(a_not_found_zero, clk, rst_n, (out_valid && !out_found) |-> ((out_chosen_slot == '0) && (out_remaining_slice == '0)), "not-found result carries nonzero payload")
  // A current task appears only when a decision commits its choice.
  `PTSS_ASSERT_RST(a_cur_from_finish, clk, rst_n, $rose(cur_valid_r) |-> ($past(state_r) == S_FINISH), "current task set outside a decision commit")
  // The first scan pass and the result hand-off never write the table.
  `PTSS_ASSERT_RST(a_no_write_in_scan, clk, rst_n, ((state_r == S_SCAN_A) || (state_r == S_DONE)) |-> !mem_req.we, "slot table written during a read-only phase")

endmodule

### design/ptss_slot_mem.sv
// Task slot memory: one write port, one registered read port, valid bit per slot.
`timescale 1ns / 1ps

module ptss_slot_mem
  import ptss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output entry_t   rd_entry
);

  entry_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  vld_r;
  entry_t                 rd_data_r;
  logic                   rd_vld_r;

  // Storage array; at most one write and one read per cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  // Valid bits: a slot never written reads as all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

### design/ptss_pick.sv
// Per-slot update and priority compare unit, applied to one slot per cycle.
`timescale 1ns / 1ps

module ptss_pick
  import ptss_pkg::*;
(
  input  entry_t            entry,
  input  logic [SLOT_W-1:0] idx,
  input  logic              refill,
  input  logic              cur_valid,
  input  logic [SLOT_W-1:0] cur_slot,
  input  pick_t             pick_in,
  output logic              wr_en,
  output entry_t            wr_entry,
  output pick_t             pick_out
);

  task_state_t        st;
  logic [SLICE_W-1:0] slc;

  // Refill the slice from the priority when a refill is due, and demote the current running task to ready.
  always_comb begin
    st  = entry.state;
    slc = refill ? entry.prio : entry.slice;
    if (cur_valid && (cur_slot == idx) && (entry.state == ST_RUNNING)) begin
      st = ST_READY;
    end
    wr_en    = entry.occ;
    wr_entry = '{occ: entry.occ, prio: entry.prio, slice: slc, state: st};
  end

  // First ready slot wins unless a later one has higher priority and time left.
  always_comb begin
    pick_out = pick_in;
    if (entry.occ && (st == ST_READY)) begin
      if (!pick_in.have) begin
        pick_out = '{have: 1'b1, idx: idx, prio: entry.prio, slice: slc};
      end else if ((entry.prio > pick_in.prio) && (slc != '0)) begin
        pick_out = '{have: 1'b1, idx: idx, prio: entry.prio, slice: slc};
      end
    end
  end

endmodule
